FILE: rtl/column_min_max_mean_decimator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the column decimator
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef COLUMN_MIN_MAX_MEAN_DECIMATOR_CORE_MACROS_SVH
`define COLUMN_MIN_MAX_MEAN_DECIMATOR_CORE_MACROS_SVH

// Checked only while out of reset.
`define COLMM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define COLMM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: rtl/colmm_pkg.sv
// ----------------------------------------------------------------------------
// colmm_pkg
// Widths, register codes, payload types and sequencer states of the
// column min/max/mean decimator.
// ----------------------------------------------------------------------------
package colmm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SAMPLES = 65536;
    localparam int COORD_BITS  = 11;

    localparam int INDEX_BITS = $clog2(MAX_SAMPLES);
    localparam int COUNT_BITS = 17;
    localparam int SUM_BITS   = 32;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  =
        (COUNT_BITS > SAMPLE_BITS) ? ((COUNT_BITS > COORD_BITS) ? COUNT_BITS : COORD_BITS)
                                   : ((SAMPLE_BITS > COORD_BITS) ? SAMPLE_BITS : COORD_BITS);

    // shared multiplier: (index or value offset) x (coordinate span)
    localparam int MUL_A_BITS = (INDEX_BITS > SAMPLE_BITS) ? INDEX_BITS + 1 : SAMPLE_BITS + 1;
    localparam int MUL_B_BITS = COORD_BITS + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

    // shared divider: signed operands, magnitudes handled inside
    localparam int DVD_MAG_BITS = (PROD_BITS - 1 > SUM_BITS) ? PROD_BITS - 1 : SUM_BITS;
    localparam int DVD_BITS     = DVD_MAG_BITS + 1;
    localparam int DVS_MAG_BITS = (COUNT_BITS > SAMPLE_BITS + 1) ? COUNT_BITS : SAMPLE_BITS + 1;
    localparam int DVS_BITS     = DVS_MAG_BITS + 1;
    localparam int ITER_BITS    = $clog2(DVD_MAG_BITS);

    localparam int ROW_SUM_BITS = DVD_BITS + 1;

    localparam logic [COUNT_BITS-1:0]  SAMPLE_COUNT_RST = COUNT_BITS'(1024);
    localparam logic [COORD_BITS-1:0]  X_LEFT_RST       = COORD_BITS'(0);
    localparam logic [COORD_BITS-1:0]  X_RIGHT_RST      = COORD_BITS'(1023);
    localparam logic [COORD_BITS-1:0]  Y_BOTTOM_RST     = COORD_BITS'(399);
    localparam logic [COORD_BITS-1:0]  Y_TOP_RST        = COORD_BITS'(0);
    localparam logic [SAMPLE_BITS-1:0] RANGE_LOW_RST    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] RANGE_HIGH_RST   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SAMPLE_COUNT,
        CFG_X_LEFT,
        CFG_X_RIGHT,
        CFG_Y_BOTTOM,
        CFG_Y_TOP,
        CFG_RANGE_LOW,
        CFG_RANGE_HIGH
    } t_cfg_index;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          final_sample;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] column_x;
        logic [COORD_BITS-1:0] row_of_min;
        logic [COORD_BITS-1:0] row_of_max;
        logic [COORD_BITS-1:0] row_of_mean;
        logic                  end_of_trace;
    } t_out_item;

    typedef struct packed {
        logic                       start;
        logic signed [DVD_BITS-1:0] dividend;
        logic signed [DVS_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                       done;
        logic signed [DVD_BITS-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [1:0] {
        ROW_MIN,
        ROW_MAX,
        ROW_MEAN
    } t_row_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COL_MUL,
        S_COL_GO,
        S_COL_WAIT,
        S_DECIDE,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_ROW_MUL,
        S_ROW_GO,
        S_ROW_WAIT,
        S_EMIT
    } t_state;

endpackage

FILE: rtl/colmm_div.sv
// ----------------------------------------------------------------------------
// colmm_div
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module colmm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  colmm_pkg::t_div_req i_req,
    output colmm_pkg::t_div_rsp o_rsp
);
    import colmm_pkg::*;

    logic                       r_busy;
    logic                       r_done;
    logic [ITER_BITS-1:0]       r_iter;
    logic [DVD_MAG_BITS-1:0]    r_quo;
    logic [DVS_MAG_BITS-1:0]    r_rem;
    logic [DVS_MAG_BITS-1:0]    r_dvs;
    logic                       r_neg;
    logic signed [DVD_BITS-1:0] r_result;

    logic signed [DVD_BITS-1:0] w_dvd_abs;
    logic signed [DVS_BITS-1:0] w_dvs_abs;
    logic [DVS_MAG_BITS:0]      w_rem_sh;
    logic                       w_fits;
    logic [DVS_MAG_BITS:0]      w_rem_sub;
    logic [DVD_MAG_BITS-1:0]    w_quo_nx;
    logic                       w_last;
    logic signed [DVD_BITS-1:0] w_quo_ext;

    assign w_dvd_abs = i_req.dividend[DVD_BITS-1] ? -i_req.dividend : i_req.dividend;
    assign w_dvs_abs = i_req.divisor[DVS_BITS-1] ? -i_req.divisor : i_req.divisor;

    assign w_rem_sh  = {r_rem, r_quo[DVD_MAG_BITS-1]};
    assign w_fits    = (w_rem_sh >= {1'b0, r_dvs});
    assign w_rem_sub = w_fits ? (w_rem_sh - {1'b0, r_dvs}) : w_rem_sh;
    assign w_quo_nx  = {r_quo[DVD_MAG_BITS-2:0], w_fits};
    assign w_last    = (r_iter == ITER_BITS'(DVD_MAG_BITS - 1));
    assign w_quo_ext = $signed({1'b0, w_quo_nx});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= w_dvd_abs[DVD_MAG_BITS-1:0];
            r_rem <= '0;
            r_dvs <= w_dvs_abs[DVS_MAG_BITS-1:0];
            r_neg <= i_req.dividend[DVD_BITS-1] ^ i_req.divisor[DVS_BITS-1];
        end else if (r_busy) begin
            r_quo <= w_quo_nx;
            r_rem <= w_rem_sub[DVS_MAG_BITS-1:0];
            if (w_last) begin
                r_result <= r_neg ? -w_quo_ext : w_quo_ext;
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_result;

endmodule

FILE: rtl/column_min_max_mean_decimator_core.sv
// Flow: an accepted sample is scaled to a column by the multiplier and the shared
// divider, then merged into its bucket. A closing column adds the mean division plus three
// row scalings, which a flat range skips; a column change on the final sample closes two columns.
// Throughput is set by the shared divider, one quotient bit a cycle; a full
// result register holds the block in the emit step until the result is taken.
// Synchronous reset restores the register defaults and leaves no bucket open.
// ----------------------------------------------------------------------------
// column_min_max_mean_decimator_core
// Bins a sample trace into screen columns, keeps per-column min, max, sum
// and count, and reports the pixel rows of each closed column.
// ----------------------------------------------------------------------------
module column_min_max_mean_decimator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [colmm_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [colmm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  colmm_pkg::t_in_item                  i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output colmm_pkg::t_out_item                 o_out_data
);
    import colmm_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [COUNT_BITS-1:0]         r_sample_count;
    logic [COORD_BITS-1:0]         r_x_left;
    logic [COORD_BITS-1:0]         r_x_right;
    logic [COORD_BITS-1:0]         r_y_bottom;
    logic [COORD_BITS-1:0]         r_y_top;
    logic signed [SAMPLE_BITS-1:0] r_range_low;
    logic signed [SAMPLE_BITS-1:0] r_range_high;

    logic [INDEX_BITS-1:0]         r_sample_index;
    logic [COORD_BITS-1:0]         r_cur_col;
    logic signed [SAMPLE_BITS-1:0] r_bkt_min;
    logic signed [SAMPLE_BITS-1:0] r_bkt_max;
    logic signed [SUM_BITS-1:0]    r_bkt_sum;
    logic [COUNT_BITS-1:0]         r_bkt_count;
    logic                          r_bkt_open;
    logic                          r_last;
    t_row_sel                      r_row_sel;
    logic                          r_out_valid;

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_final;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic [COORD_BITS-1:0]         r_new_col;
    logic signed [SAMPLE_BITS-1:0] r_mean;
    logic [COORD_BITS-1:0]         r_row_min;
    logic [COORD_BITS-1:0]         r_row_max;
    logic [COORD_BITS-1:0]         r_row_mean;
    t_out_item                     r_out;

    logic [COUNT_BITS-1:0]         w_cnt_eff;
    logic [COUNT_BITS-1:0]         w_bkt_cnt_eff;
    logic signed [MUL_B_BITS-1:0]  w_dx;
    logic signed [MUL_B_BITS-1:0]  w_dy;
    logic signed [SAMPLE_BITS:0]   w_den;
    logic                          w_den_zero;
    logic signed [SAMPLE_BITS-1:0] w_row_v;
    logic signed [SAMPLE_BITS:0]   w_vd;
    logic signed [MUL_A_BITS-1:0]  w_mul_a;
    logic signed [MUL_B_BITS-1:0]  w_mul_b;
    logic signed [PROD_BITS-1:0]   w_mul_p;
    logic [COORD_BITS-1:0]         w_col;
    logic signed [ROW_SUM_BITS-1:0] w_row_sum;
    logic [COORD_BITS-1:0]         w_row_res;
    logic signed [SUM_BITS:0]      w_sum_ext;
    logic signed [SUM_BITS-1:0]    w_sum_sat;
    logic [INDEX_BITS-1:0]         w_idx_next;
    logic                          w_col_change;
    logic                          w_out_load;
    logic                          w_in_accept;
    t_div_req                      w_div_req;
    t_div_rsp                      w_div_rsp;

    colmm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    assign w_cnt_eff     = (r_sample_count == '0) ? COUNT_BITS'(1) : r_sample_count;
    assign w_bkt_cnt_eff = (r_bkt_count == '0) ? COUNT_BITS'(1) : r_bkt_count;
    assign w_dx = $signed({1'b0, r_x_right}) - $signed({1'b0, r_x_left});
    assign w_dy = $signed({1'b0, r_y_top}) - $signed({1'b0, r_y_bottom});
    assign w_den = $signed({r_range_high[SAMPLE_BITS-1], r_range_high})
                 - $signed({r_range_low[SAMPLE_BITS-1], r_range_low});
    assign w_den_zero = (w_den == '0);

    always_comb begin
        case (r_row_sel)
            ROW_MIN: w_row_v = r_bkt_min;
            ROW_MAX: w_row_v = r_bkt_max;
            default: w_row_v = r_mean;
        endcase
    end

    assign w_vd = $signed({w_row_v[SAMPLE_BITS-1], w_row_v})
                - $signed({r_range_low[SAMPLE_BITS-1], r_range_low});

    assign w_mul_p = w_mul_a * w_mul_b;

    assign w_col = r_x_left + w_div_rsp.quotient[COORD_BITS-1:0];

    // clamp the scaled row into the coordinate width (negative to zero, overflow to all ones)
    assign w_row_sum = ROW_SUM_BITS'($signed({1'b0, r_y_bottom}))
                     + ROW_SUM_BITS'(w_div_rsp.quotient);
    always_comb begin
        if (w_row_sum[ROW_SUM_BITS-1]) begin
            w_row_res = '0;
        end else if (|w_row_sum[ROW_SUM_BITS-2:COORD_BITS]) begin
            w_row_res = '1;
        end else begin
            w_row_res = w_row_sum[COORD_BITS-1:0];
        end
    end

    assign w_sum_ext = (SUM_BITS+1)'(r_bkt_sum) + (SUM_BITS+1)'(r_sample);
    always_comb begin
        if (w_sum_ext[SUM_BITS] != w_sum_ext[SUM_BITS-1]) begin
            w_sum_sat = w_sum_ext[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                            : {1'b0, {(SUM_BITS-1){1'b1}}};
        end else begin
            w_sum_sat = w_sum_ext[SUM_BITS-1:0];
        end
    end

    assign w_idx_next = (r_sample_index == INDEX_BITS'(MAX_SAMPLES - 1)) ? '0
                                                                        : r_sample_index + 1'b1;
    assign w_col_change = r_bkt_open && (r_new_col != r_cur_col);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_COL_MUL;
            S_COL_MUL:   n_state = S_COL_GO;
            S_COL_GO:    n_state = S_COL_WAIT;
            S_COL_WAIT:  if (w_div_rsp.done) n_state = S_DECIDE;
            S_DECIDE: begin
                n_state = (r_final || w_col_change) ? S_MEAN_GO : S_IDLE;
            end
            S_MEAN_GO:   n_state = S_MEAN_WAIT;
            S_MEAN_WAIT: if (w_div_rsp.done) n_state = S_ROW_MUL;
            S_ROW_MUL: begin
                if (!w_den_zero) begin
                    n_state = S_ROW_GO;
                end else if (r_row_sel == ROW_MEAN) begin
                    n_state = S_EMIT;
                end
            end
            S_ROW_GO:    n_state = S_ROW_WAIT;
            S_ROW_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = (r_row_sel == ROW_MEAN) ? S_EMIT : S_ROW_MUL;
                end
            end
            S_EMIT: begin
                if (w_out_load) begin
                    n_state = (!r_last && r_final) ? S_MEAN_GO : S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready         = 1'b0;
        w_out_load         = 1'b0;
        w_mul_a            = MUL_A_BITS'(w_vd);
        w_mul_b            = w_dy;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = DVD_BITS'(r_prod);
        w_div_req.divisor  = DVS_BITS'(w_den);
        case (r_state)
            S_IDLE:    o_in_ready = 1'b1;
            S_COL_MUL: begin
                w_mul_a = $signed(MUL_A_BITS'({1'b0, r_sample_index}));
                w_mul_b = w_dx;
            end
            S_COL_GO: begin
                w_div_req.start   = 1'b1;
                w_div_req.divisor = $signed(DVS_BITS'({1'b0, w_cnt_eff}));
            end
            S_MEAN_GO: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = DVD_BITS'(r_bkt_sum);
                w_div_req.divisor  = $signed(DVS_BITS'({1'b0, w_bkt_cnt_eff}));
            end
            S_ROW_GO:  w_div_req.start = 1'b1;
            S_EMIT:    w_out_load = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign w_in_accept = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Control, configuration and bucket state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sample_count <= SAMPLE_COUNT_RST;
            r_x_left       <= X_LEFT_RST;
            r_x_right      <= X_RIGHT_RST;
            r_y_bottom     <= Y_BOTTOM_RST;
            r_y_top        <= Y_TOP_RST;
            r_range_low    <= RANGE_LOW_RST;
            r_range_high   <= RANGE_HIGH_RST;
            r_sample_index <= '0;
            r_cur_col      <= '0;
            r_bkt_min      <= '0;
            r_bkt_max      <= '0;
            r_bkt_sum      <= '0;
            r_bkt_count    <= '0;
            r_bkt_open     <= 1'b0;
            r_last         <= 1'b0;
            r_row_sel      <= ROW_MIN;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[COUNT_BITS-1:0];
                    CFG_X_LEFT:       r_x_left       <= i_cfg_data[COORD_BITS-1:0];
                    CFG_X_RIGHT:      r_x_right      <= i_cfg_data[COORD_BITS-1:0];
                    CFG_Y_BOTTOM:     r_y_bottom     <= i_cfg_data[COORD_BITS-1:0];
                    CFG_Y_TOP:        r_y_top        <= i_cfg_data[COORD_BITS-1:0];
                    CFG_RANGE_LOW:    r_range_low    <= i_cfg_data[SAMPLE_BITS-1:0];
                    CFG_RANGE_HIGH:   r_range_high   <= i_cfg_data[SAMPLE_BITS-1:0];
                    default: begin
                    end
                endcase
            end

            // load a fresh result, else drop the one just taken
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_DECIDE: begin
                    r_row_sel <= ROW_MIN;
                    if (!r_bkt_open) begin
                        r_cur_col   <= r_new_col;
                        r_bkt_min   <= r_sample;
                        r_bkt_max   <= r_sample;
                        r_bkt_sum   <= SUM_BITS'(r_sample);
                        r_bkt_count <= COUNT_BITS'(1);
                        r_bkt_open  <= 1'b1;
                        r_last      <= 1'b1;
                        if (!r_final) r_sample_index <= w_idx_next;
                    end else if (w_col_change) begin
                        // close the old bucket first, open the new one after it is sent
                        r_last <= 1'b0;
                    end else begin
                        if (r_sample < r_bkt_min) r_bkt_min <= r_sample;
                        if (r_sample > r_bkt_max) r_bkt_max <= r_sample;
                        r_bkt_sum <= w_sum_sat;
                        if (r_bkt_count != '1) r_bkt_count <= r_bkt_count + 1'b1;
                        r_last <= 1'b1;
                        if (!r_final) r_sample_index <= w_idx_next;
                    end
                end
                S_ROW_MUL: begin
                    if (w_den_zero && r_row_sel != ROW_MEAN) begin
                        r_row_sel <= (r_row_sel == ROW_MIN) ? ROW_MAX : ROW_MEAN;
                    end
                end
                S_ROW_WAIT: begin
                    if (w_div_rsp.done && r_row_sel != ROW_MEAN) begin
                        r_row_sel <= (r_row_sel == ROW_MIN) ? ROW_MAX : ROW_MEAN;
                    end
                end
                S_EMIT: begin
                    if (w_out_load) begin
                        if (r_last) begin
                            r_bkt_open     <= 1'b0;
                            r_sample_index <= '0;
                        end else begin
                            r_cur_col   <= r_new_col;
                            r_bkt_min   <= r_sample;
                            r_bkt_max   <= r_sample;
                            r_bkt_sum   <= SUM_BITS'(r_sample);
                            r_bkt_count <= COUNT_BITS'(1);
                            r_bkt_open  <= 1'b1;
                            r_last      <= 1'b1;
                            r_row_sel   <= ROW_MIN;
                            if (!r_final) r_sample_index <= w_idx_next;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_sample <= i_in_data.sample;
            r_final  <= i_in_data.final_sample;
        end

        case (r_state)
            S_COL_MUL: r_prod <= w_mul_p;
            S_COL_WAIT: begin
                if (w_div_rsp.done) r_new_col <= w_col;
            end
            S_MEAN_WAIT: begin
                if (w_div_rsp.done) r_mean <= w_div_rsp.quotient[SAMPLE_BITS-1:0];
            end
            S_ROW_MUL: begin
                r_prod <= w_mul_p;
                // flat range: every row sits on the bottom line
                if (w_den_zero) begin
                    case (r_row_sel)
                        ROW_MIN: r_row_min  <= r_y_bottom;
                        ROW_MAX: r_row_max  <= r_y_bottom;
                        default: r_row_mean <= r_y_bottom;
                    endcase
                end
            end
            S_ROW_WAIT: begin
                if (w_div_rsp.done) begin
                    case (r_row_sel)
                        ROW_MIN: r_row_min  <= w_row_res;
                        ROW_MAX: r_row_max  <= w_row_res;
                        default: r_row_mean <= w_row_res;
                    endcase
                end
            end
            S_EMIT: begin
                if (w_out_load) begin
                    r_out.column_x     <= r_cur_col;
                    r_out.row_of_min   <= r_row_min;
                    r_out.row_of_max   <= r_row_max;
                    r_out.row_of_mean  <= r_row_mean;
                    r_out.end_of_trace <= r_last;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/colmm_checker.sv
// ----------------------------------------------------------------------------
// colmm_checker
// Port-level checks of the column decimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "column_min_max_mean_decimator_core_macros.svh"

module colmm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input colmm_pkg::t_out_item                 o_out_data
);

    // reset leaves the block idle with nothing to send
    `COLMM_ASSERT_ALWAYS(a_reset_idle, i_clk, (!i_rst_n |=> (!o_out_valid && o_in_ready)), "block not idle after reset")

    // a stalled result holds
    `COLMM_ASSERT(a_out_hold, i_clk, i_rst_n, ((o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data))), "stalled result changed")

    // one sample at a time: busy right after a transaction
    `COLMM_ASSERT(a_busy_after_accept, i_clk, i_rst_n, ((i_in_valid && o_in_ready) |=> !o_in_ready), "input taken while busy")

    // a new result is only produced while a sample is in work
    `COLMM_ASSERT(a_result_while_busy, i_clk, i_rst_n, ($rose(o_out_valid) |-> $past(!o_in_ready)), "result appeared while idle")

endmodule

bind column_min_max_mean_decimator_core colmm_checker u_colmm_checker (.*);
